// ===== sv/scsa_pkg.sv =====
// Shared constants, types and the class capacity table of the size class slot allocator.
package scsa_pkg;

   localparam int NUM_CLASSES     = 13;
   localparam int SLOTS_PER_CLASS = 64;

   localparam int CLASS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SLOT_W     = $clog2(SLOTS_PER_CLASS);
   localparam int SLOT_CNT_W = $clog2(SLOTS_PER_CLASS + 1);

   // port field widths
   localparam int SIZE_W       = 32;
   localparam int CLS_FIELD_W  = 4;
   localparam int SLOT_FIELD_W = 6;
   localparam int STATUS_W     = 2;
   localparam int NCLS_W       = 4;
   localparam int NSLOT_W      = 7;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [NCLS_W-1:0]  CLASSES_RESET = 4'd13;
   localparam logic [NSLOT_W-1:0] SLOTS_RESET   = 7'd64;

   // register select, taken from paddr bit 2
   localparam logic REG_CLASSES_IN_USE = 1'b0;
   localparam logic REG_SLOTS_IN_USE   = 1'b1;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED  = 2'd0,
      ST_SYSTEM   = 2'd1,
      ST_RELEASED = 2'd2,
      ST_OUTSIDE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_SCAN,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic fetch;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic fetch_done;
      logic scan_done;
      logic out_free;
   } stat_type;

   function automatic logic [SIZE_W-1:0] class_capacity(input int idx);
      logic [SIZE_W-1:0] cap;
      unique case (idx)
         0:       cap = 32'd16;
         1:       cap = 32'd64;
         2:       cap = 32'd256;
         3:       cap = 32'd1024;
         4:       cap = 32'd2048;
         5:       cap = 32'd4096;
         6:       cap = 32'(1024 * 16);
         7:       cap = 32'(1024 * 64);
         8:       cap = 32'(1024 * 256);
         9:       cap = 32'(1024 * 1024);
         10:      cap = 32'(1024 * 1024 * 2);
         11:      cap = 32'(1024 * 1024 * 4);
         12:      cap = 32'(1024 * 1024 * 16);
         default: cap = 32'd0;
      endcase
      return cap;
   endfunction

endpackage

// ===== sv/scsa_ram.sv =====
// Generic single write port RAM with registered read.
module scsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/scsa_csr.sv =====
// Configuration registers behind the APB-style port.
module scsa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [scsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [scsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [scsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [scsa_pkg::NCLS_W-1:0]       classes_in_use,
   output logic [scsa_pkg::NSLOT_W-1:0]      slots_in_use
);
   import scsa_pkg::*;

   logic [NCLS_W-1:0]  classes_ff, classes_in;
   logic [NSLOT_W-1:0] slots_ff, slots_in;
   logic               wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      classes_in = classes_ff;
      slots_in   = slots_ff;
      if (wr_hit) begin
         unique case (csr_paddr[2])
            REG_CLASSES_IN_USE: classes_in = csr_pwdata[NCLS_W-1:0];
            REG_SLOTS_IN_USE:   slots_in   = csr_pwdata[NSLOT_W-1:0];
            default:            classes_in = classes_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_CLASSES_IN_USE: csr_prdata = CSR_DATA_W'(classes_ff);
         REG_SLOTS_IN_USE:   csr_prdata = CSR_DATA_W'(slots_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         classes_ff <= CLASSES_RESET;
         slots_ff   <= SLOTS_RESET;
      end else begin
         classes_ff <= classes_in;
         slots_ff   <= slots_in;
      end
   end

   assign classes_in_use = classes_ff;
   assign slots_in_use   = slots_ff;

endmodule

// ===== sv/scsa_ctrl.sv =====
// Sequencer for one request at a time: decode, row fetch, slot scan, commit.
module scsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  scsa_pkg::stat_type  stat,
   output logic                req_ready,
   output scsa_pkg::cmd_type   cmd
);
   import scsa_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECODE;
         S_DECODE: state_in = stat.skip ? S_COMMIT : S_FETCH;
         S_FETCH:  state_in = stat.fetch_done ? S_COMMIT : S_SCAN;
         S_SCAN:   if (stat.scan_done) state_in = S_COMMIT;
         S_COMMIT: if (stat.out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECODE: cmd.lookup = 1'b1;
         S_FETCH:  cmd.fetch  = 1'b1;
         S_SCAN:   cmd.scan   = 1'b1;
         S_COMMIT: cmd.commit = 1'b1;
         default:  cmd        = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/scsa_datapath.sv =====
// Request registers, class lookup, used-mark rows, bump positions and result register.
module scsa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  scsa_pkg::cmd_type                   cmd,
   output scsa_pkg::stat_type                  stat,
   input  logic                                req_kind,
   input  logic [scsa_pkg::SIZE_W-1:0]         req_request_size,
   input  logic                                req_release_in_pool,
   input  logic [scsa_pkg::CLS_FIELD_W-1:0]    req_release_class,
   input  logic [scsa_pkg::SLOT_FIELD_W-1:0]   req_release_slot,
   input  logic [scsa_pkg::NCLS_W-1:0]         classes_in_use,
   input  logic [scsa_pkg::NSLOT_W-1:0]        slots_in_use,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [scsa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [scsa_pkg::CLS_FIELD_W-1:0]    rsp_granted_class,
   output logic [scsa_pkg::SLOT_FIELD_W-1:0]   rsp_granted_slot
);
   import scsa_pkg::*;

   // captured request
   logic                    kind_ff, kind_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic                    in_pool_ff, in_pool_in;
   logic [CLS_FIELD_W-1:0]  rel_class_ff, rel_class_in;
   logic [SLOT_FIELD_W-1:0] rel_slot_ff, rel_slot_in;

   // working state
   logic [CLASS_W-1:0]         cls_ff, cls_in;
   logic [SLOT_CNT_W-1:0]      idx_ff, idx_in;
   logic [SLOTS_PER_CLASS-1:0] row_ff, row_in;
   status_type                 res_status_ff, res_status_in;
   logic [CLASS_W-1:0]         res_class_ff, res_class_in;
   logic [SLOT_W-1:0]          res_slot_ff, res_slot_in;
   logic                       wr_pend_ff, wr_pend_in;

   // reset-cleared state
   logic [SLOT_CNT_W-1:0] bump_ff [NUM_CLASSES];
   logic [SLOT_CNT_W-1:0] bump_in [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] row_valid_ff, row_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // result register
   status_type              rsp_status_ff, rsp_status_in;
   logic [CLS_FIELD_W-1:0]  rsp_class_ff, rsp_class_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;

   // combinational
   logic [NCLS_W-1:0]          ncls_eff;
   logic [SLOT_CNT_W-1:0]      nslot_eff;
   logic [CLASS_W-1:0]         fit_class;
   logic                       fit_found;
   logic                       release_bad;
   logic [CLASS_W-1:0]         lookup_class;
   logic [SLOTS_PER_CLASS-1:0] ram_rd_data;
   logic [SLOTS_PER_CLASS-1:0] row_now;
   logic [SLOT_CNT_W-1:0]      bump_pos;
   logic                       bump_hit;
   logic [SLOT_W-1:0]          rel_idx;
   logic [SLOT_W-1:0]          scan_idx;
   logic                       scan_end;
   logic                       scan_free;
   logic                       out_free;
   logic                       ram_wr_en;

   assign ncls_eff  = (classes_in_use > NCLS_W'(NUM_CLASSES)) ? NCLS_W'(NUM_CLASSES)
                                                              : classes_in_use;
   assign nslot_eff = (32'(slots_in_use) > 32'(SLOTS_PER_CLASS)) ?
                      SLOT_CNT_W'(SLOTS_PER_CLASS) : SLOT_CNT_W'(slots_in_use);

   // smallest searched class that holds the size; a zero size fits wherever one byte does
   always_comb begin
      fit_class = '0;
      fit_found = 1'b0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if ((NCLS_W'(c) < ncls_eff) && (class_capacity(c) >= size_ff)) begin
            fit_class = CLASS_W'(c);
            fit_found = 1'b1;
         end
      end
   end

   assign release_bad  = !in_pool_ff ||
                         (32'(rel_class_ff) >= 32'(NUM_CLASSES)) ||
                         (32'(rel_slot_ff) >= 32'(SLOTS_PER_CLASS));
   assign lookup_class = (kind_ff == KIND_RELEASE) ? CLASS_W'(rel_class_ff) : fit_class;

   // a row never written reads as all free
   assign row_now  = row_valid_ff[cls_ff] ? ram_rd_data : '0;
   assign bump_pos = bump_ff[cls_ff];
   assign bump_hit = (kind_ff == KIND_ALLOC) && (bump_pos < nslot_eff) &&
                     !row_now[bump_pos[SLOT_W-1:0]];
   assign rel_idx  = SLOT_W'(rel_slot_ff);

   assign scan_idx  = idx_ff[SLOT_W-1:0];
   assign scan_end  = idx_ff >= nslot_eff;
   assign scan_free = !row_ff[scan_idx];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ram_wr_en = cmd.commit && wr_pend_ff;

   assign stat.skip       = (kind_ff == KIND_RELEASE) ? release_bad : !fit_found;
   assign stat.fetch_done = (kind_ff == KIND_RELEASE) || bump_hit;
   assign stat.scan_done  = scan_end || scan_free;
   assign stat.out_free   = out_free;

   always_comb begin
      kind_in       = kind_ff;
      size_in       = size_ff;
      in_pool_in    = in_pool_ff;
      rel_class_in  = rel_class_ff;
      rel_slot_in   = rel_slot_ff;
      cls_in        = cls_ff;
      idx_in        = idx_ff;
      row_in        = row_ff;
      res_status_in = res_status_ff;
      res_class_in  = res_class_ff;
      res_slot_in   = res_slot_ff;
      wr_pend_in    = wr_pend_ff;
      bump_in       = bump_ff;
      row_valid_in  = row_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_slot_in   = rsp_slot_ff;

      if (cmd.capture) begin
         kind_in      = req_kind;
         size_in      = req_request_size;
         in_pool_in   = req_release_in_pool;
         rel_class_in = req_release_class;
         rel_slot_in  = req_release_slot;
      end

      if (cmd.lookup) begin
         cls_in       = lookup_class;
         idx_in       = '0;
         res_class_in = '0;
         res_slot_in  = '0;
         wr_pend_in   = 1'b0;
         res_status_in = (kind_ff == KIND_RELEASE) ? ST_OUTSIDE : ST_SYSTEM;
      end

      if (cmd.fetch) begin
         row_in = row_now;
         if (kind_ff == KIND_RELEASE) begin
            row_in[rel_idx] = 1'b0;
            res_status_in   = ST_RELEASED;
            wr_pend_in      = 1'b1;
         end else if (bump_hit) begin
            row_in[bump_pos[SLOT_W-1:0]] = 1'b1;
            bump_in[cls_ff] = bump_pos + SLOT_CNT_W'(1);
            res_status_in   = ST_GRANTED;
            res_class_in    = cls_ff;
            res_slot_in     = bump_pos[SLOT_W-1:0];
            wr_pend_in      = 1'b1;
         end
      end

      if (cmd.scan) begin
         if (scan_end) begin
            res_status_in = ST_SYSTEM;
            wr_pend_in    = 1'b0;
         end else if (scan_free) begin
            row_in[scan_idx] = 1'b1;
            res_status_in    = ST_GRANTED;
            res_class_in     = cls_ff;
            res_slot_in      = scan_idx;
            wr_pend_in       = 1'b1;
         end else begin
            idx_in = idx_ff + SLOT_CNT_W'(1);
         end
      end

      // the row write may repeat while the result waits; it is the same data
      if (ram_wr_en) begin
         row_valid_in[cls_ff] = 1'b1;
      end

      if (cmd.commit && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_class_in  = CLS_FIELD_W'(res_class_ff);
         rsp_slot_in   = SLOT_FIELD_W'(res_slot_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff      <= '{default: '0};
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bump_ff      <= bump_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      in_pool_ff    <= in_pool_in;
      rel_class_ff  <= rel_class_in;
      rel_slot_ff   <= rel_slot_in;
      cls_ff        <= cls_in;
      idx_ff        <= idx_in;
      row_ff        <= row_in;
      res_status_ff <= res_status_in;
      res_class_ff  <= res_class_in;
      res_slot_ff   <= res_slot_in;
      wr_pend_ff    <= wr_pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   scsa_ram #(
      .WIDTH (SLOTS_PER_CLASS),
      .DEPTH (NUM_CLASSES)
   ) u_marks (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cls_ff),
      .wr_data (row_ff),
      .rd_en   (cmd.lookup),
      .rd_addr (lookup_class),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_class = rsp_class_ff;
   assign rsp_granted_slot  = rsp_slot_ff;

endmodule

// ===== sv/size_class_slot_allocator_unit.sv =====
// Path: a bump hit or release goes from accept through DECODE, FETCH and COMMIT
// to rsp_valid; rejects skip FETCH, and a miss adds a SCAN from slot 0.
// A new request is taken only in IDLE, once the last one has left COMMIT with
// its result handed to the output register.
// Reset (synchronous, active high): all slots free, bump positions zero,
// classes_in_use 13, slots_in_use 64; no clearing pass, the block is ready at once.
module size_class_slot_allocator_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [scsa_pkg::SIZE_W-1:0]         req_request_size,
   input  logic                                req_release_in_pool,
   input  logic [scsa_pkg::CLS_FIELD_W-1:0]    req_release_class,
   input  logic [scsa_pkg::SLOT_FIELD_W-1:0]   req_release_slot,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [scsa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [scsa_pkg::CLS_FIELD_W-1:0]    rsp_granted_class,
   output logic [scsa_pkg::SLOT_FIELD_W-1:0]   rsp_granted_slot,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scsa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [scsa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [scsa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import scsa_pkg::*;

   // The controller walks IDLE -> DECODE -> (FETCH -> (SCAN)) -> COMMIT.
   //  DECODE : pick the class (or check the release handle), start the row read
   //  FETCH  : row arrives; release clears its bit, a free bump slot is taken
   //  SCAN   : one used mark per cycle from slot 0 until a free one or the end
   //  COMMIT : write a changed row back and hand the result to the output register
   // The output register lets a finished result wait while the next request
   // is taken in.

   cmd_type            cmd;
   stat_type           stat;
   logic [NCLS_W-1:0]  classes_in_use;
   logic [NSLOT_W-1:0] slots_in_use;

   scsa_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .classes_in_use (classes_in_use),
      .slots_in_use   (slots_in_use)
   );

   scsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Used marks live in a 13 x 64 RAM (one row per class) inside the datapath;
   // per-row valid bits make unwritten rows read as free after reset.
   scsa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_kind            (req_kind),
      .req_request_size    (req_request_size),
      .req_release_in_pool (req_release_in_pool),
      .req_release_class   (req_release_class),
      .req_release_slot    (req_release_slot),
      .classes_in_use      (classes_in_use),
      .slots_in_use        (slots_in_use),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_class   (rsp_granted_class),
      .rsp_granted_slot    (rsp_granted_slot)
   );

endmodule

// ===== sv/scsa_checker.sv =====
// Port-level checks of the allocator and their binding to the top level.
module scsa_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [scsa_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [scsa_pkg::CLS_FIELD_W-1:0]    rsp_granted_class,
   input  logic [scsa_pkg::SLOT_FIELD_W-1:0]   rsp_granted_slot
);
   import scsa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_granted_class) && $stable(rsp_granted_slot))
      else $error("result changed while stalled");

   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_GRANTED) |->
      (rsp_granted_class == '0) && (rsp_granted_slot == '0))
      else $error("handle fields set on a result that grants nothing");

   a_class_built: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_GRANTED) |->
      (rsp_granted_class < CLS_FIELD_W'(NUM_CLASSES)))
      else $error("granted class beyond the built classes");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in work");

endmodule

bind size_class_slot_allocator_unit scsa_checker u_scsa_checker (.*);

// ===== sim/size_class_slot_allocator_unit_tb.sv =====
// Self-checking testbench for the size class slot allocator: directed corners, then random traffic.
`timescale 1ns / 100ps

module size_class_slot_allocator_unit_tb;
   import scsa_pkg::*;

   // cycles with no request or result moving before the run is called hung
   localparam int STALL_LIMIT   = 2000;
   // quiet time before a register write and at the end; covers a full-class scan
   localparam int SETTLE_CYCLES = 2 * SLOTS_PER_CLASS + 8;
   localparam int REPORT_LIMIT  = 10;

   // bytes each class can hold, smallest first
   localparam logic [SIZE_W-1:0] CAPACITY_BYTES [NUM_CLASSES] = '{
      32'd16, 32'd64, 32'd256, 32'd1024, 32'd2048, 32'd4096,
      32'd16384, 32'd65536, 32'd262144, 32'd1048576, 32'd2097152,
      32'd4194304, 32'd16777216
   };

   // random phases: register settings and request count per phase
   localparam int NUM_PHASES = 9;
   localparam int PHASE_CLASSES [NUM_PHASES] = '{13, 1, 15, 13, 0, 13, 5, 13, 12};
   localparam int PHASE_SLOTS   [NUM_PHASES] = '{64, 1, 127, 6, 5, 0, 64, 2, 64};
   localparam int PHASE_ITEMS   [NUM_PHASES] = '{110, 50, 90, 90, 25, 25, 90, 80, 90};

   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SQUARE,
      READY_SPARSE
   } stall_mode_type;

   typedef struct {
      logic                    kind;
      logic [SIZE_W-1:0]       nbytes;
      logic                    in_pool;
      logic [CLS_FIELD_W-1:0]  cls;
      logic [SLOT_FIELD_W-1:0] slot;
   } request_type;

   typedef struct {
      status_type              status;
      logic [CLS_FIELD_W-1:0]  cls;
      logic [SLOT_FIELD_W-1:0] slot;
   } outcome_type;

   typedef struct {
      logic [CLS_FIELD_W-1:0]  cls;
      logic [SLOT_FIELD_W-1:0] slot;
   } handle_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_kind;
   logic [SIZE_W-1:0]       req_request_size;
   logic                    req_release_in_pool;
   logic [CLS_FIELD_W-1:0]  req_release_class;
   logic [SLOT_FIELD_W-1:0] req_release_slot;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [STATUS_W-1:0]     rsp_status;
   logic [CLS_FIELD_W-1:0]  rsp_granted_class;
   logic [SLOT_FIELD_W-1:0] rsp_granted_slot;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // shadow of the pool: used marks, bump positions and both registers
   bit                  slot_taken [NUM_CLASSES][SLOTS_PER_CLASS];
   bit [NSLOT_W-1:0]    next_bump  [NUM_CLASSES];
   logic [NCLS_W-1:0]   pool_classes;
   logic [NSLOT_W-1:0]  pool_slots;

   outcome_type expected_outcomes [$];
   handle_type  live_handles [$];

   int burst_left;
   int error_count;
   int requests_sent;
   int register_writes;
   int count_granted;
   int count_system;
   int count_released;
   int count_outside;

   size_class_slot_allocator_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_request_size    (req_request_size),
      .req_release_in_pool (req_release_in_pool),
      .req_release_class   (req_release_class),
      .req_release_slot    (req_release_slot),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_class   (rsp_granted_class),
      .rsp_granted_slot    (rsp_granted_slot),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Outcome of one request against the shadow pool; updates the shadow as it goes.
   // Allocate: smallest searched class that fits, bump slot first, then first free
   // slot from 0; a full class falls back to the system allocator, never a bigger class.
   function automatic outcome_type predict_outcome(request_type rq);
      outcome_type       res;
      int                ncls;
      int                nslot;
      int                c;
      int                i;
      logic [SIZE_W-1:0] want_bytes;
      bit                settled;
      res.status = ST_SYSTEM;
      res.cls    = '0;
      res.slot   = '0;
      // oversized register values saturate to the built pool
      ncls  = (pool_classes > NUM_CLASSES) ? NUM_CLASSES : int'(pool_classes);
      nslot = (pool_slots > SLOTS_PER_CLASS) ? SLOTS_PER_CLASS : int'(pool_slots);
      if (rq.kind == KIND_RELEASE) begin
         // foreign or off-pool handles leave the marks alone
         if (!rq.in_pool || rq.cls >= NUM_CLASSES || rq.slot >= SLOTS_PER_CLASS) begin
            res.status = ST_OUTSIDE;
         end else begin
            // clears even past slots_in_use; freeing a free slot is harmless
            slot_taken[rq.cls][rq.slot] = 1'b0;
            res.status = ST_RELEASED;
         end
         return res;
      end
      want_bytes = (rq.nbytes == '0) ? 32'd1 : rq.nbytes;
      settled = 1'b0;
      for (c = 0; c < ncls && !settled; c++) begin
         if (CAPACITY_BYTES[c] >= want_bytes) begin
            settled = 1'b1;
            // a bump position at or past slots_in_use is stale: go straight to the scan
            if (next_bump[c] < nslot && !slot_taken[c][next_bump[c]]) begin
               slot_taken[c][next_bump[c]] = 1'b1;
               res.status = ST_GRANTED;
               res.cls    = CLS_FIELD_W'(c);
               res.slot   = SLOT_FIELD_W'(next_bump[c]);
               next_bump[c] = next_bump[c] + 1'b1;
            end else begin
               for (i = 0; i < nslot && res.status != ST_GRANTED; i++) begin
                  if (!slot_taken[c][i]) begin
                     slot_taken[c][i] = 1'b1;
                     res.status = ST_GRANTED;
                     res.cls    = CLS_FIELD_W'(c);
                     res.slot   = SLOT_FIELD_W'(i);
                  end
               end
            end
         end
      end
      return res;
   endfunction

   // Size mix: mostly the small classes so they fill, some exact boundaries,
   // some zero and some anywhere in the 32-bit range.
   function automatic logic [SIZE_W-1:0] pick_size();
      int                roll;
      int                c;
      logic [SIZE_W-1:0] lo;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         return $urandom();
      if (roll < 12)
         return '0;
      c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_CLASSES - 1) : $urandom_range(0, 3);
      if (roll < 22)
         return CAPACITY_BYTES[c] + $urandom_range(0, 1);
      lo = (c == 0) ? 32'd1 : CAPACITY_BYTES[c - 1] + 32'd1;
      return lo + $urandom_range(0, CAPACITY_BYTES[c] - lo);
   endfunction

   // Present one request, hold it until accepted, then log its expected outcome.
   // The sender runs in bursts; valid may drop for a random gap between bursts.
   task automatic send_request(request_type rq);
      outcome_type res;
      int          gap;
      req_valid           <= 1'b1;
      req_kind            <= rq.kind;
      req_request_size    <= rq.nbytes;
      req_release_in_pool <= rq.in_pool;
      req_release_class   <= rq.cls;
      req_release_slot    <= rq.slot;
      do @(posedge clock); while (!req_ready);
      res = predict_outcome(rq);
      expected_outcomes.push_back(res);
      if (res.status == ST_GRANTED)
         live_handles.push_back('{cls: res.cls, slot: res.slot});
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_alloc(logic [SIZE_W-1:0] nbytes);
      request_type rq;
      rq.kind    = KIND_ALLOC;
      rq.nbytes  = nbytes;
      rq.in_pool = 1'($urandom_range(0, 1));
      rq.cls     = CLS_FIELD_W'($urandom_range(0, 15));
      rq.slot    = SLOT_FIELD_W'($urandom_range(0, 63));
      send_request(rq);
   endtask

   task automatic send_release(logic in_pool, logic [CLS_FIELD_W-1:0] cls,
                               logic [SLOT_FIELD_W-1:0] slot);
      request_type rq;
      rq.kind    = KIND_RELEASE;
      rq.nbytes  = $urandom();
      rq.in_pool = in_pool;
      rq.cls     = cls;
      rq.slot    = slot;
      send_request(rq);
   endtask

   // Drop valid, let every outstanding result drain, then give the block time to go quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; lands on the edge with pready high.
   task automatic write_register(logic reg_sel, logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == REG_CLASSES_IN_USE)
         pool_classes = value[NCLS_W-1:0];
      else
         pool_slots = value[NSLOT_W-1:0];
      register_writes++;
   endtask

   // Class boundaries at reset settings: zero size, exact fits, one past, oversize.
   task automatic test_capacity_boundaries();
      send_alloc(32'd0);
      send_alloc(32'd16);
      send_alloc(32'd17);
      send_alloc(32'd1024);
      send_alloc(32'd4096);
      send_alloc(32'd1048576);
      send_alloc(32'd16777216);
      send_alloc(32'd16777217);
      send_alloc(32'hFFFF_FFFF);
   endtask

   // Release paths: good handle, foreign handle, class off the pool, double free,
   // a never-used slot, then an allocate to show release leaves the bump alone.
   task automatic test_release_paths();
      send_release(1'b1, 4'd0, 6'd1);
      send_release(1'b0, 4'd0, 6'd0);
      send_release(1'b1, 4'd13, 6'd0);
      send_release(1'b1, 4'd15, 6'd63);
      send_release(1'b1, 4'd0, 6'd1);
      send_release(1'b1, 4'd12, 6'd63);
      send_alloc(32'd1);
   endtask

   // Register corners: no classes, saturated classes, no slots, saturated slots,
   // then a tiny pool where the bump goes stale and the class fills up.
   task automatic test_register_extremes();
      write_register(REG_CLASSES_IN_USE, 32'd0);
      send_alloc(32'd1);
      write_register(REG_CLASSES_IN_USE, 32'd15);
      send_alloc(32'd16777216);
      write_register(REG_SLOTS_IN_USE, 32'd0);
      send_alloc(32'd1);
      write_register(REG_SLOTS_IN_USE, 32'd127);
      send_alloc(32'd2048);
      write_register(REG_CLASSES_IN_USE, 32'd1);
      write_register(REG_SLOTS_IN_USE, 32'd3);
      send_alloc(32'd17);
      send_alloc(32'd1);
      send_alloc(32'd1);
      send_release(1'b1, 4'd0, 6'd40);
      send_release(1'b1, 4'd0, 6'd0);
      send_alloc(32'd8);
   endtask

   // Random traffic over a spread of register settings. Mostly allocates and
   // releases of handles actually granted; the rest is foreign, off-pool or
   // double releases with random fields.
   task automatic test_random_traffic();
      int          p;
      int          n;
      int          choice;
      int          idx;
      handle_type  h;
      for (p = 0; p < NUM_PHASES; p++) begin
         write_register(REG_CLASSES_IN_USE, PHASE_CLASSES[p]);
         write_register(REG_SLOTS_IN_USE, PHASE_SLOTS[p]);
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            choice = $urandom_range(0, 99);
            if (choice < 50) begin
               send_alloc(pick_size());
            end else if (choice < 85 && live_handles.size() != 0) begin
               idx = $urandom_range(0, live_handles.size() - 1);
               h = live_handles[idx];
               live_handles.delete(idx);
               send_release(1'b1, h.cls, h.slot);
            end else begin
               send_release(1'($urandom_range(0, 1)),
                            CLS_FIELD_W'($urandom_range(0, 15)),
                            SLOT_FIELD_W'($urandom_range(0, 63)));
            end
         end
      end
   endtask

   // Result side: ready follows a randomly chosen mode that changes after a random span.
   initial begin : result_stalls
      stall_mode_type mode;
      int             span;
      int             period;
      int             tick;
      rsp_ready <= 1'b0;
      tick = 0;
      forever begin
         mode   = stall_mode_type'($urandom_range(0, 3));
         span   = $urandom_range(20, 200);
         period = $urandom_range(2, 12);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
               READY_SQUARE: rsp_ready <= ((tick % period) < (period / 2 + 1));
               default:      rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Each result is matched against the oldest outstanding expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_status)
            ST_GRANTED:  count_granted++;
            ST_SYSTEM:   count_system++;
            ST_RELEASED: count_released++;
            default:     count_outside++;
         endcase
         if (expected_outcomes.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result: status %0d class %0d slot %0d",
                        rsp_status, rsp_granted_class, rsp_granted_slot);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status || rsp_granted_class !== want.cls ||
                rsp_granted_slot !== want.slot) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("mismatch: expected status %0d class %0d slot %0d, got %0d %0d %0d",
                           want.status, want.cls, want.slot,
                           rsp_status, rsp_granted_class, rsp_granted_slot);
            end
         end
      end
   end

   // Hang detector: resets whenever a request or a result moves.
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_outcomes.size());
      $display("size_class_slot_allocator_unit_tb failed");
      $finish;
   end

   initial begin
      // shadow starts from the reset state: all slots free, bumps at zero
      pool_classes    = CLASSES_RESET;
      pool_slots      = SLOTS_RESET;
      burst_left      = 0;
      error_count     = 0;
      requests_sent   = 0;
      register_writes = 0;
      count_granted   = 0;
      count_system    = 0;
      count_released  = 0;
      count_outside   = 0;

      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_kind            <= KIND_ALLOC;
      req_request_size    <= '0;
      req_release_in_pool <= 1'b0;
      req_release_class   <= '0;
      req_release_slot    <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_capacity_boundaries();
      test_release_paths();
      test_register_extremes();
      test_random_traffic();

      wait_idle();
      $display("checked %0d requests: %0d grants, %0d system fallbacks, %0d releases, %0d outside",
               requests_sent, count_granted, count_system, count_released, count_outside);
      $display("over %0d register writes incl. zero and saturated class and slot counts",
               register_writes);
      if (error_count == 0) begin
         $display("size_class_slot_allocator_unit_tb passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("size_class_slot_allocator_unit_tb failed");
      end
      $finish;
   end

endmodule

// ===== size_class_slot_allocator_unit.f =====
sv/scsa_pkg.sv
sv/scsa_ram.sv
sv/scsa_csr.sv
sv/scsa_ctrl.sv
sv/scsa_datapath.sv
sv/size_class_slot_allocator_unit.sv
sv/scsa_checker.sv
sim/size_class_slot_allocator_unit_tb.sv
